// ===== src/siha_pkg.sv =====
// siha_pkg: constants, codes and control/status types for the sorted index allocator
// no dependencies; imported by every module of the block except siha_ram
package siha_pkg;

    localparam int INDEX_DEPTH  = 1024;
    localparam int HOLE_DEPTH   = 1024;
    localparam int HEADER_BYTES = 4;

    localparam int IDX_AW  = $clog2(INDEX_DEPTH);
    localparam int IDX_CW  = IDX_AW + 1;
    localparam int HOLE_AW = $clog2(HOLE_DEPTH);
    localparam int HOLE_CW = HOLE_AW + 1;
    localparam int NEED_W  = 17;
    localparam int IDX_DW  = 80;
    localparam int HOLE_DW = 64;

    localparam logic [1:0] MODE_ADD  = 2'd0;
    localparam logic [1:0] MODE_FIND = 2'd1;
    localparam logic [1:0] MODE_DEL  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    typedef enum logic [5:0] {
        OP_NOP, OP_LOAD, OP_BS_READ, OP_BS_STEP, OP_POS_READ,
        OP_RES_ZERO, OP_RES_FIND, OP_ERR_DUP, OP_ERR_MISS, OP_ERR_FULL,
        OP_DEL_BEGIN, OP_SCAN_INIT, OP_SCAN_READ, OP_SCAN_NEXT, OP_APPEND, OP_TAKE,
        OP_HREM_READ, OP_HREM_WRITE, OP_HREM_DONE, OP_HINS,
        OP_SORT_READ_I, OP_SORT_LATCH, OP_SORT_READ_J, OP_SORT_SHIFT, OP_SORT_PLACE,
        OP_ISH_READ, OP_ISH_WRITE, OP_ISH_PLACE, OP_DSH_READ, OP_DSH_WRITE, OP_DSH_DONE
    } op_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic       lt;
        logic       present;
        logic       idx_full;
        logic       hole_full;
        logic       scan_more;
        logic       fits;
        logic       append_ovf;
        logic       rem_more;
        logic       rest_nz;
        logic       sortable;
        logic       outer_more;
        logic       inner_more;
        logic       ahead;
        logic       ish_more;
        logic       dsh_more;
        logic [1:0] mode;
    } dp_stat_t;

endpackage

// ===== src/siha_ram.sv =====
// siha_ram: generic single-write, single-read memory with registered read data
// no dependencies
module siha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/siha_datapath.sv =====
// siha_datapath: index and hole memories, pointers, counters and result registers
// depends on siha_pkg and siha_ram
module siha_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  siha_pkg::dp_cmd_t     cmd,
    output siha_pkg::dp_stat_t    stat,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_wr_data,
    input  logic [1:0]            mode,
    input  logic signed [31:0]    record_key,
    input  logic [15:0]           record_length,
    output logic                  done,
    output logic [1:0]            status,
    output logic [31:0]           record_offset,
    output logic [15:0]           found_length
);
    import siha_pkg::*;

    logic [1:0]          strat_reg, strat_next;
    logic [1:0]          sorted_reg, sorted_next;
    logic [1:0]          mode_reg, mode_next;
    logic [31:0]         key_reg, key_next;
    logic [15:0]         len_reg, len_next;
    logic [IDX_CW-1:0]   lo_reg, lo_next, hi_reg, hi_next;
    logic [IDX_CW-1:0]   icount_reg, icount_next, ip_reg, ip_next;
    logic [HOLE_CW-1:0]  hcount_reg, hcount_next, hp_reg, hp_next, so_reg, so_next;
    logic [31:0]         end_reg, end_next;
    logic [31:0]         off_reg, off_next, rest_reg, rest_next;
    logic [31:0]         s_reg, s_next, o_reg, o_next;
    logic                done_reg, done_next;
    logic [1:0]          rstat_reg, rstat_next;
    logic [31:0]         roff_reg, roff_next;
    logic [15:0]         rlen_reg, rlen_next;

    logic                i_we, i_re, h_we, h_re;
    logic [IDX_CW-1:0]   i_wa, i_ra;
    logic [HOLE_CW-1:0]  h_wa, h_ra;
    logic [IDX_DW-1:0]   i_wd, i_rd;
    logic [HOLE_DW-1:0]  h_wd, h_rd;

    logic [IDX_CW:0]     lh_sum;
    logic [IDX_CW-1:0]   mid;
    logic [NEED_W-1:0]   need;
    logic [32:0]         app_sum;
    logic [31:0]         rd_key, rd_off, h_size, h_off;
    logic [15:0]         rd_len;

    siha_ram #(.WIDTH(IDX_DW), .DEPTH(INDEX_DEPTH)) u_idx_ram (
        .clk(clk), .wr_en(i_we), .wr_addr(i_wa[IDX_AW-1:0]), .wr_data(i_wd),
        .rd_en(i_re), .rd_addr(i_ra[IDX_AW-1:0]), .rd_data(i_rd)
    );

    siha_ram #(.WIDTH(HOLE_DW), .DEPTH(HOLE_DEPTH)) u_hole_ram (
        .clk(clk), .wr_en(h_we), .wr_addr(h_wa[HOLE_AW-1:0]), .wr_data(h_wd),
        .rd_en(h_re), .rd_addr(h_ra[HOLE_AW-1:0]), .rd_data(h_rd)
    );

    assign rd_key = i_rd[79:48];
    assign rd_off = i_rd[47:16];
    assign rd_len = i_rd[15:0];
    assign h_size = h_rd[63:32];
    assign h_off  = h_rd[31:0];

    assign lh_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = lh_sum[IDX_CW:1];
    assign need    = NEED_W'(HEADER_BYTES) + NEED_W'(len_reg);
    assign app_sum = {1'b0, end_reg} + 33'(need);

    // status towards the controller
    always_comb
    begin
        stat.lt         = lo_reg < hi_reg;
        stat.present    = (lo_reg < icount_reg) && (rd_key == key_reg);
        stat.idx_full   = icount_reg >= IDX_CW'(INDEX_DEPTH);
        stat.hole_full  = hcount_reg >= HOLE_CW'(HOLE_DEPTH);
        stat.scan_more  = hp_reg < hcount_reg;
        stat.fits       = h_size >= 32'(need);
        stat.append_ovf = app_sum[32];
        stat.rem_more   = ({1'b0, hp_reg} + 1'b1) < {1'b0, hcount_reg};
        stat.rest_nz    = rest_reg != 32'd0;
        stat.sortable   = (strat_reg == FIT_BEST) || (strat_reg == FIT_WORST);
        stat.outer_more = so_reg < hcount_reg;
        stat.inner_more = hp_reg != '0;
        if (s_reg != h_size)
        begin
            stat.ahead = (strat_reg == FIT_WORST) ? (s_reg > h_size) : (s_reg < h_size);
        end
        else
        begin
            stat.ahead = o_reg < h_off;
        end
        stat.ish_more   = ip_reg > lo_reg;
        stat.dsh_more   = ({1'b0, ip_reg} + 1'b1) < {1'b0, icount_reg};
        stat.mode       = mode_reg;
    end

    always_comb
    begin
        strat_next  = cfg_wr_en ? cfg_wr_data : strat_reg;
        sorted_next = sorted_reg;
        mode_next   = mode_reg;
        key_next    = key_reg;
        len_next    = len_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        icount_next = icount_reg;
        ip_next     = ip_reg;
        hcount_next = hcount_reg;
        hp_next     = hp_reg;
        so_next     = so_reg;
        end_next    = end_reg;
        off_next    = off_reg;
        rest_next   = rest_reg;
        s_next      = s_reg;
        o_next      = o_reg;
        done_next   = 1'b0;
        rstat_next  = rstat_reg;
        roff_next   = roff_reg;
        rlen_next   = rlen_reg;
        i_we = 1'b0; i_re = 1'b0; h_we = 1'b0; h_re = 1'b0;
        i_wa = ip_reg; i_ra = lo_reg; i_wd = i_rd;
        h_wa = hp_reg; h_ra = hp_reg; h_wd = h_rd;

        case (cmd.op)
            OP_LOAD:
            begin
                mode_next = mode;
                key_next  = record_key;
                len_next  = record_length;
                lo_next   = '0;
                hi_next   = icount_reg;
            end
            OP_BS_READ:
            begin
                i_re = 1'b1;
                i_ra = mid;
            end
            OP_BS_STEP:
            begin
                if ($signed(rd_key) < $signed(key_reg))
                begin
                    lo_next = mid + 1'b1;
                end
                else
                begin
                    hi_next = mid;
                end
            end
            OP_POS_READ:
            begin
                i_re = 1'b1;
                i_ra = lo_reg;
            end
            OP_RES_ZERO:
            begin
                done_next = 1'b1; rstat_next = ST_OK; roff_next = '0; rlen_next = '0;
            end
            OP_RES_FIND:
            begin
                done_next = 1'b1; rstat_next = ST_OK; roff_next = rd_off; rlen_next = rd_len;
            end
            OP_ERR_DUP:
            begin
                done_next = 1'b1; rstat_next = ST_DUP; roff_next = '0; rlen_next = '0;
            end
            OP_ERR_MISS:
            begin
                done_next = 1'b1; rstat_next = ST_MISS; roff_next = '0; rlen_next = '0;
            end
            OP_ERR_FULL:
            begin
                done_next = 1'b1; rstat_next = ST_FULL; roff_next = '0; rlen_next = '0;
            end
            OP_DEL_BEGIN:
            begin
                roff_next = rd_off;
                rlen_next = rd_len;
                s_next    = 32'(HEADER_BYTES) + 32'(rd_len);
                o_next    = rd_off;
                ip_next   = lo_reg;
            end
            OP_SCAN_INIT:
            begin
                hp_next = '0;
            end
            OP_SCAN_READ:
            begin
                h_re = 1'b1;
                h_ra = hp_reg;
            end
            OP_SCAN_NEXT:
            begin
                hp_next = hp_reg + 1'b1;
            end
            OP_APPEND:
            begin
                off_next = end_reg;
                end_next = app_sum[31:0];
                ip_next  = icount_reg;
            end
            OP_TAKE:
            begin
                off_next  = h_off;
                rest_next = h_size - 32'(need);
                ip_next   = icount_reg;
            end
            OP_HREM_READ:
            begin
                h_re = 1'b1;
                h_ra = hp_reg + 1'b1;
            end
            OP_HREM_WRITE:
            begin
                h_we    = 1'b1;
                h_wa    = hp_reg;
                hp_next = hp_reg + 1'b1;
            end
            OP_HREM_DONE:
            begin
                hcount_next = hcount_reg - 1'b1;
                s_next      = rest_reg;
                o_next      = off_reg + 32'(need);
            end
            OP_HINS:
            begin
                h_we        = 1'b1;
                h_wa        = hcount_reg;
                h_wd        = {s_reg, o_reg};
                hcount_next = hcount_reg + 1'b1;
                // list already in this order: only the new entry needs placing; else the whole list is sorted again
                if (stat.sortable)
                begin
                    so_next     = (sorted_reg == strat_reg) ? hcount_reg : HOLE_CW'(1);
                    sorted_next = strat_reg;
                end
                else
                begin
                    sorted_next = FIT_FIRST;
                end
            end
            OP_SORT_READ_I:
            begin
                h_re    = 1'b1;
                h_ra    = so_reg;
                hp_next = so_reg;
            end
            OP_SORT_LATCH:
            begin
                s_next = h_size;
                o_next = h_off;
            end
            OP_SORT_READ_J:
            begin
                h_re = 1'b1;
                h_ra = hp_reg - 1'b1;
            end
            OP_SORT_SHIFT:
            begin
                h_we    = 1'b1;
                h_wa    = hp_reg;
                hp_next = hp_reg - 1'b1;
            end
            OP_SORT_PLACE:
            begin
                h_we    = 1'b1;
                h_wa    = hp_reg;
                h_wd    = {s_reg, o_reg};
                so_next = so_reg + 1'b1;
            end
            OP_ISH_READ:
            begin
                i_re = 1'b1;
                i_ra = ip_reg - 1'b1;
            end
            OP_ISH_WRITE:
            begin
                i_we    = 1'b1;
                i_wa    = ip_reg;
                ip_next = ip_reg - 1'b1;
            end
            OP_ISH_PLACE:
            begin
                i_we        = 1'b1;
                i_wa        = lo_reg;
                i_wd        = {key_reg, off_reg, len_reg};
                icount_next = icount_reg + 1'b1;
                done_next   = 1'b1;
                rstat_next  = ST_OK;
                roff_next   = off_reg;
                rlen_next   = len_reg;
            end
            OP_DSH_READ:
            begin
                i_re = 1'b1;
                i_ra = ip_reg + 1'b1;
            end
            OP_DSH_WRITE:
            begin
                i_we    = 1'b1;
                i_wa    = ip_reg;
                ip_next = ip_reg + 1'b1;
            end
            OP_DSH_DONE:
            begin
                icount_next = icount_reg - 1'b1;
                done_next   = 1'b1;
                rstat_next  = ST_OK;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strat_reg  <= FIT_FIRST;
            sorted_reg <= FIT_FIRST;
            icount_reg <= '0;
            hcount_reg <= '0;
            end_reg    <= '0;
            done_reg   <= 1'b0;
            mode_reg   <= MODE_ADD;
            key_reg    <= '0;
            len_reg    <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            ip_reg     <= '0;
            hp_reg     <= '0;
            so_reg     <= '0;
            off_reg    <= '0;
            rest_reg   <= '0;
            s_reg      <= '0;
            o_reg      <= '0;
            rstat_reg  <= ST_OK;
            roff_reg   <= '0;
            rlen_reg   <= '0;
        end
        else
        begin
            strat_reg  <= strat_next;
            sorted_reg <= sorted_next;
            icount_reg <= icount_next;
            hcount_reg <= hcount_next;
            end_reg    <= end_next;
            done_reg   <= done_next;
            mode_reg   <= mode_next;
            key_reg    <= key_next;
            len_reg    <= len_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            ip_reg     <= ip_next;
            hp_reg     <= hp_next;
            so_reg     <= so_next;
            off_reg    <= off_next;
            rest_reg   <= rest_next;
            s_reg      <= s_next;
            o_reg      <= o_next;
            rstat_reg  <= rstat_next;
            roff_reg   <= roff_next;
            rlen_reg   <= rlen_next;
        end
    end

    assign done          = done_reg;
    assign status        = rstat_reg;
    assign record_offset = roff_reg;
    assign found_length  = rlen_reg;

endmodule

// ===== src/siha_ctrl.sv =====
// siha_ctrl: sequencer that steps the datapath through search, scan, sort and shift
// depends on siha_pkg
module siha_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  siha_pkg::dp_stat_t  stat,
    output siha_pkg::dp_cmd_t   cmd
);
    import siha_pkg::*;

    typedef enum logic [16:0] {
        S_IDLE      = 17'h00001,
        S_BS_RD     = 17'h00002,
        S_BS_CMP    = 17'h00004,
        S_POS       = 17'h00008,
        S_SCAN_RD   = 17'h00010,
        S_SCAN_CMP  = 17'h00020,
        S_HREM_RD   = 17'h00040,
        S_HREM_WR   = 17'h00080,
        S_HINS      = 17'h00100,
        S_SORT_OUT  = 17'h00200,
        S_SORT_LOAD = 17'h00400,
        S_SORT_IN   = 17'h00800,
        S_SORT_CMP  = 17'h01000,
        S_ISH_RD    = 17'h02000,
        S_ISH_WR    = 17'h04000,
        S_DSH_RD    = 17'h08000,
        S_DSH_WR    = 17'h10000
    } state_t;

    state_t state_reg, state_next;
    state_t after_ins;

    assign after_ins = (stat.mode == MODE_ADD) ? S_ISH_RD : S_DSH_RD;
    assign busy      = state_reg != S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_BS_RD;
                end
            end
            S_BS_RD:
            begin
                if (stat.lt)
                begin
                    cmd.op     = OP_BS_READ;
                    state_next = S_BS_CMP;
                end
                else
                begin
                    cmd.op     = OP_POS_READ;
                    state_next = S_POS;
                end
            end
            S_BS_CMP:
            begin
                cmd.op     = OP_BS_STEP;
                state_next = S_BS_RD;
            end
            S_POS:
            begin
                state_next = S_IDLE;
                case (stat.mode)
                    MODE_ADD:
                    begin
                        if (stat.present)
                        begin
                            cmd.op = OP_ERR_DUP;
                        end
                        else if (stat.idx_full)
                        begin
                            cmd.op = OP_ERR_FULL;
                        end
                        else
                        begin
                            cmd.op     = OP_SCAN_INIT;
                            state_next = S_SCAN_RD;
                        end
                    end
                    MODE_FIND:
                    begin
                        cmd.op = stat.present ? OP_RES_FIND : OP_ERR_MISS;
                    end
                    MODE_DEL:
                    begin
                        if (!stat.present)
                        begin
                            cmd.op = OP_ERR_MISS;
                        end
                        else if (stat.hole_full)
                        begin
                            cmd.op = OP_ERR_FULL;
                        end
                        else
                        begin
                            cmd.op     = OP_DEL_BEGIN;
                            state_next = S_HINS;
                        end
                    end
                    default:
                    begin
                        cmd.op = OP_RES_ZERO;
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                if (stat.scan_more)
                begin
                    cmd.op     = OP_SCAN_READ;
                    state_next = S_SCAN_CMP;
                end
                else if (stat.append_ovf)
                begin
                    cmd.op     = OP_ERR_FULL;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = OP_APPEND;
                    state_next = S_ISH_RD;
                end
            end
            S_SCAN_CMP:
            begin
                if (stat.fits)
                begin
                    cmd.op     = OP_TAKE;
                    state_next = S_HREM_RD;
                end
                else
                begin
                    cmd.op     = OP_SCAN_NEXT;
                    state_next = S_SCAN_RD;
                end
            end
            S_HREM_RD:
            begin
                if (stat.rem_more)
                begin
                    cmd.op     = OP_HREM_READ;
                    state_next = S_HREM_WR;
                end
                else
                begin
                    cmd.op     = OP_HREM_DONE;
                    state_next = stat.rest_nz ? S_HINS : S_ISH_RD;
                end
            end
            S_HREM_WR:
            begin
                cmd.op     = OP_HREM_WRITE;
                state_next = S_HREM_RD;
            end
            S_HINS:
            begin
                cmd.op     = OP_HINS;
                state_next = stat.sortable ? S_SORT_OUT : after_ins;
            end
            S_SORT_OUT:
            begin
                if (stat.outer_more)
                begin
                    cmd.op     = OP_SORT_READ_I;
                    state_next = S_SORT_LOAD;
                end
                else
                begin
                    state_next = after_ins;
                end
            end
            S_SORT_LOAD:
            begin
                cmd.op     = OP_SORT_LATCH;
                state_next = S_SORT_IN;
            end
            S_SORT_IN:
            begin
                if (stat.inner_more)
                begin
                    cmd.op     = OP_SORT_READ_J;
                    state_next = S_SORT_CMP;
                end
                else
                begin
                    cmd.op     = OP_SORT_PLACE;
                    state_next = S_SORT_OUT;
                end
            end
            S_SORT_CMP:
            begin
                if (stat.ahead)
                begin
                    cmd.op     = OP_SORT_SHIFT;
                    state_next = S_SORT_IN;
                end
                else
                begin
                    cmd.op     = OP_SORT_PLACE;
                    state_next = S_SORT_OUT;
                end
            end
            S_ISH_RD:
            begin
                if (stat.ish_more)
                begin
                    cmd.op     = OP_ISH_READ;
                    state_next = S_ISH_WR;
                end
                else
                begin
                    cmd.op     = OP_ISH_PLACE;
                    state_next = S_IDLE;
                end
            end
            S_ISH_WR:
            begin
                cmd.op     = OP_ISH_WRITE;
                state_next = S_ISH_RD;
            end
            S_DSH_RD:
            begin
                if (stat.dsh_more)
                begin
                    cmd.op     = OP_DSH_READ;
                    state_next = S_DSH_WR;
                end
                else
                begin
                    cmd.op     = OP_DSH_DONE;
                    state_next = S_IDLE;
                end
            end
            S_DSH_WR:
            begin
                cmd.op     = OP_DSH_WRITE;
                state_next = S_DSH_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/sorted_index_with_hole_allocator.sv =====
// sorted_index_with_hole_allocator: top level of the record index and hole allocator
// depends on siha_pkg, siha_ctrl and siha_datapath
//
// one request at a time: a request is taken when start is high and busy low, and
// its single result appears for exactly one cycle with done high; the receiver
// cannot stall it, so it must take the result in that cycle. a request costs a
// binary search of the key index (a read and a compare per step), then for add a
// scan of the hole list (a read and a compare per hole looked at), removal of the
// used hole (a read and a write per entry behind it), and an index shift of a read
// and a write per record above the key; delete shifts the index down the same way.
// inserting a hole in best or worst fit sorts in only the new entry, or runs a
// full insertion sort of the list (quadratic in its length) when the fit order
// was changed since the list was last ordered. everything is limited by the
// single read and write port of each memory. the fit register must be written
// only while busy is low; the block itself does not enforce it. no clearing pass
// is needed
module sorted_index_with_hole_allocator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         mode,
    input  logic signed [31:0] record_key,
    input  logic [15:0]        record_length,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_wr_data,
    output logic               done,
    output logic [1:0]         status,
    output logic [31:0]        record_offset,
    output logic [15:0]        found_length
);
    import siha_pkg::*;

    // command and status between sequencer and datapath
    dp_cmd_t  cmd;
    dp_stat_t stat;

    siha_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // memories, pointers and the registered request result
    siha_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .mode          (mode),
        .record_key    (record_key),
        .record_length (record_length),
        .done          (done),
        .status        (status),
        .record_offset (record_offset),
        .found_length  (found_length)
    );

endmodule

// ===== sim/testbench.sv =====
// testbench: self-checking bench for the sorted index allocator with hole list
// depends on siha_pkg and sorted_index_with_hole_allocator; an internal allocator
// model predicts each untyped result, a monitor compares each done strobe against the expectations
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import siha_pkg::*;

    // codes the package leaves out
    localparam logic [1:0] MODE_IDLE = 2'd3;  // no operation
    localparam logic [1:0] FIT_ALT   = 2'd3;  // behaves as first fit

    localparam int WATCHDOG_LIMIT = 1000000;
    localparam int PHASE_ITEMS    = 40;
    localparam int TAIL_ITEMS     = 30;
    localparam int POOL_SIZE      = 16;

    typedef struct packed {
        logic [1:0]  st;
        logic [31:0] off;
        logic [15:0] len;
    } outcome_t;

    typedef struct {
        logic [1:0]         m;
        logic signed [31:0] k;
        logic [15:0]        l;
        bit                 typed;
        outcome_t           o;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         req_mode = '0;
    logic signed [31:0] req_key = '0;
    logic [15:0]        req_length = '0;
    logic               cfg_wr_en = 1'b0;
    logic [1:0]         cfg_wr_data = '0;
    logic               done;
    logic [1:0]         status;
    logic [31:0]        record_offset;
    logic [15:0]        found_length;

    // allocator model state
    logic [1:0]         model_fit;
    logic signed [31:0] rec_key [INDEX_DEPTH];
    logic [31:0]        rec_off [INDEX_DEPTH];
    logic [15:0]        rec_len [INDEX_DEPTH];
    int                 rec_cnt;
    logic [31:0]        hole_size [HOLE_DEPTH];
    logic [31:0]        hole_off [HOLE_DEPTH];
    int                 hole_cnt;
    logic [31:0]        file_end;

    outcome_t           pending_outcomes [$];
    logic signed [31:0] key_pool [POOL_SIZE];
    int                 mismatches = 0;
    int                 quiet_cycles = 0;
    bit                 sender_idles = 1'b1;

    // directed requests from reset in first fit; typed results where obvious
    stim_row_t directed [20] = '{
        '{MODE_FIND, 32'sd5, 16'd0, 1'b1, '{ST_MISS, 32'd0, 16'd0}},
        '{MODE_DEL, 32'sd5, 16'd0, 1'b1, '{ST_MISS, 32'd0, 16'd0}},
        '{MODE_ADD, 32'h8000_0000, 16'd0, 1'b1, '{ST_OK, 32'd0, 16'd0}},
        '{MODE_ADD, 32'h7FFF_FFFF, 16'hFFFF, 1'b1, '{ST_OK, 32'd4, 16'hFFFF}},
        '{MODE_ADD, 32'h8000_0000, 16'd7, 1'b1, '{ST_DUP, 32'd0, 16'd0}},
        '{MODE_FIND, 32'h7FFF_FFFF, 16'd0, 1'b1, '{ST_OK, 32'd4, 16'hFFFF}},
        '{MODE_IDLE, 32'sd0, 16'hFFFF, 1'b1, '{ST_OK, 32'd0, 16'd0}},
        '{MODE_ADD, 32'sd0, 16'd10, 1'b1, '{ST_OK, 32'd65543, 16'd10}},
        '{MODE_DEL, 32'h7FFF_FFFF, 16'd0, 1'b1, '{ST_OK, 32'd4, 16'hFFFF}},
        '{MODE_ADD, 32'sd1, 16'd100, 1'b0, '0},
        '{MODE_ADD, -32'sd1, 16'd65431, 1'b0, '0},
        '{MODE_FIND, -32'sd1, 16'd0, 1'b0, '0},
        '{MODE_DEL, 32'sd0, 16'd0, 1'b0, '0},
        '{MODE_DEL, 32'h8000_0000, 16'd0, 1'b0, '0},
        '{MODE_ADD, 32'sd2, 16'd3, 1'b0, '0},
        '{MODE_FIND, 32'sd2, 16'd0, 1'b0, '0},
        '{MODE_DEL, -32'sd1, 16'd0, 1'b0, '0},
        '{MODE_ADD, 32'h5555_5555, 16'hAAAA, 1'b0, '0},
        '{MODE_ADD, 32'hAAAA_AAAA, 16'h5555, 1'b0, '0},
        '{MODE_FIND, 32'sd3, 16'd0, 1'b1, '{ST_MISS, 32'd0, 16'd0}}
    };

    logic [1:0] phase_fit [6] = '{FIT_BEST, FIT_WORST, FIT_ALT, FIT_FIRST, FIT_WORST, FIT_BEST};

    sorted_index_with_hole_allocator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (req_mode),
        .record_key    (req_key),
        .record_length (req_length),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .done          (done),
        .status        (status),
        .record_offset (record_offset),
        .found_length  (found_length)
    );

    always #5 clk = ~clk;

    // ordering of holes in best fit (ascending) and worst fit (descending)
    function automatic bit hole_ahead(logic [31:0] sa, logic [31:0] oa,
                                      logic [31:0] sb, logic [31:0] ob, bit desc);
        if (sa != sb)
            return desc ? (sa > sb) : (sa < sb);
        return oa < ob;
    endfunction

    // append a hole, then re-sort the whole list in best or worst fit
    function automatic void add_hole(logic [31:0] sz, logic [31:0] off);
        logic [31:0] s;
        logic [31:0] o;
        int          j;
        hole_size[hole_cnt] = sz;
        hole_off[hole_cnt]  = off;
        hole_cnt++;
        if (model_fit != FIT_BEST && model_fit != FIT_WORST)
            return;
        for (int i = 1; i < hole_cnt; i++)
        begin
            s = hole_size[i];
            o = hole_off[i];
            j = i;
            while (j > 0 && hole_ahead(s, o, hole_size[j-1], hole_off[j-1],
                                       model_fit == FIT_WORST))
            begin
                hole_size[j] = hole_size[j-1];
                hole_off[j]  = hole_off[j-1];
                j--;
            end
            hole_size[j] = s;
            hole_off[j]  = o;
        end
    endfunction

    // applies one request to the model and returns its result
    function automatic outcome_t allocate(logic [1:0] m, logic signed [31:0] k, logic [15:0] l);
        outcome_t    r;
        int          pos;
        int          hit;
        bit          present;
        logic [31:0] need;
        logic [31:0] rest;
        logic [31:0] off;
        r = '0;
        pos = 0;
        hit = -1;
        off = '0;
        while (pos < rec_cnt && rec_key[pos] < k)
            pos++;
        present = (pos < rec_cnt) && (rec_key[pos] == k);
        case (m)
            MODE_ADD:
            begin
                need = HEADER_BYTES + l;
                if (present)
                    r.st = ST_DUP;
                else if (rec_cnt >= INDEX_DEPTH)
                    r.st = ST_FULL;
                else
                begin
                    for (int h = 0; h < hole_cnt && hit < 0; h++)
                        if (hole_size[h] >= need)
                            hit = h;
                    if (hit >= 0)
                    begin
                        rest = hole_size[hit] - need;
                        off  = hole_off[hit];
                        for (int j = hit; j + 1 < hole_cnt; j++)
                        begin
                            hole_size[j] = hole_size[j+1];
                            hole_off[j]  = hole_off[j+1];
                        end
                        hole_cnt--;
                        if (rest != 0)
                            add_hole(rest, off + need);
                    end
                    else if ({32'd0, file_end} + need > 64'hFFFF_FFFF)
                        r.st = ST_FULL;
                    else
                    begin
                        off = file_end;
                        file_end = file_end + need;
                    end
                    if (r.st == ST_OK)
                    begin
                        for (int j = rec_cnt; j > pos; j--)
                        begin
                            rec_key[j] = rec_key[j-1];
                            rec_off[j] = rec_off[j-1];
                            rec_len[j] = rec_len[j-1];
                        end
                        rec_key[pos] = k;
                        rec_off[pos] = off;
                        rec_len[pos] = l;
                        rec_cnt++;
                        r.off = off;
                        r.len = l;
                    end
                end
            end
            MODE_FIND:
            begin
                if (!present)
                    r.st = ST_MISS;
                else
                begin
                    r.off = rec_off[pos];
                    r.len = rec_len[pos];
                end
            end
            MODE_DEL:
            begin
                if (!present)
                    r.st = ST_MISS;
                else if (hole_cnt >= HOLE_DEPTH)
                    r.st = ST_FULL;
                else
                begin
                    r.off = rec_off[pos];
                    r.len = rec_len[pos];
                    add_hole(HEADER_BYTES + r.len, r.off);
                    for (int j = pos; j + 1 < rec_cnt; j++)
                    begin
                        rec_key[j] = rec_key[j+1];
                        rec_off[j] = rec_off[j+1];
                        rec_len[j] = rec_len[j+1];
                    end
                    rec_cnt--;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // drive one request from a falling edge, wait for it to be taken, log its result
    task automatic issue(logic [1:0] m, logic signed [31:0] k, logic [15:0] l,
                         bit use_typed, outcome_t typed_val);
        outcome_t p;
        req_mode   = m;
        req_key    = k;
        req_length = l;
        start      = 1'b1;
        do
            @(posedge clk);
        while (busy);
        p = allocate(m, k, l);
        pending_outcomes.push_back(use_typed ? typed_val : p);
        @(negedge clk);
        // start is left high so a following request is driven without a gap, unless a random pause is drawn
        if (sender_idles && $urandom_range(0, 3) == 0)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    endtask

    // register write only once every result is in and the block is idle
    task automatic set_fit(logic [1:0] v);
        start = 1'b0;
        while (pending_outcomes.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        while (busy)
            @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        model_fit = v;
    endtask

    // random request: mostly keys from a small pool so adds, finds and deletes meet
    task automatic random_request();
        logic [1:0]         m;
        logic signed [31:0] k;
        logic [15:0]        l;
        int                 pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            m = MODE_ADD;
        else if (pick < 65)
            m = MODE_FIND;
        else if (pick < 95)
            m = MODE_DEL;
        else
            m = MODE_IDLE;
        if ($urandom_range(0, 9) < 8)
            k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            k = $urandom;
        case ($urandom_range(0, 9))
            0: l = 16'd0;
            1: l = 16'hFFFF;
            2: l = $urandom;
            default: l = $urandom_range(0, 200);
        endcase
        issue(m, k, l, 1'b0, '0);
    endtask

    // result check: oldest expectation first, every field
    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n && done)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("unexpected result: status %0d offset %0d length %0d",
                       status, record_offset, found_length);
                mismatches++;
            end
            else
            begin
                e = pending_outcomes.pop_front();
                if (status !== e.st)
                begin
                    $error("status: expected %0d, got %0d", e.st, status);
                    mismatches++;
                end
                if (record_offset !== e.off)
                begin
                    $error("record_offset: expected %0d, got %0d", e.off, record_offset);
                    mismatches++;
                end
                if (found_length !== e.len)
                begin
                    $error("found_length: expected %0d, got %0d", e.len, found_length);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with neither a request taken nor a result seen
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial
    begin
        model_fit = FIT_FIRST;
        rec_cnt   = 0;
        hole_cnt  = 0;
        file_end  = '0;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = -32'sd1;
        key_pool[3] = 32'sd0;
        key_pool[4] = 32'sd1;
        for (int i = 5; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
            issue(directed[i].m, directed[i].k, directed[i].l, directed[i].typed, directed[i].o);

        // random phases, the fit order changing between them
        foreach (phase_fit[p])
        begin
            set_fit(phase_fit[p]);
            repeat (PHASE_ITEMS) random_request();
        end

        // last part, requests back to back with no idling
        sender_idles = 1'b0;
        repeat (TAIL_ITEMS) random_request();

        start = 1'b0;
        while (pending_outcomes.size() != 0)
            @(negedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
